// ===== rtl/lla_pkg.sv =====
`timescale 1ns / 1ps

package lla_pkg;

   // field widths fixed by the interface
   localparam int CMD_W       = 2;
   localparam int COORD_W     = 6;
   localparam int MASK_W      = 9;
   localparam int SIZE_W      = 7;
   localparam int COUNT_W     = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   // neighbour count 0..8
   localparam int NBR_W      = 4;
   localparam int MASK_EXT_W = 2 ** NBR_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH_MASK   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURVIVE_MASK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH        = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT       = 2'd3;

   localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
   localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;
   localparam logic [SIZE_W-1:0] SIZE_RESET    = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_STEP  = 2'd2
   } lla_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRIME0,
      ST_PRIME1,
      ST_SCAN,
      ST_REPLY
   } lla_state_type;

   // sequencer to cell unit
   typedef struct packed {
      logic clear;
      logic scan;
      logic advance;
      logic load_valid;
      logic first_col;
      logic last_col;
      logic in_region;
   } lla_win_ctl_type;

endpackage

// ===== rtl/lla_row_mem.sv =====
`timescale 1ns / 1ps

module lla_row_mem #(
   parameter int DATA_W = 64,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lla_cell_unit.sv =====
`timescale 1ns / 1ps

module lla_cell_unit #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic                           clock,
   input  lla_pkg::lla_win_ctl_type       ctl,
   input  logic [MAX_COLUMNS-1:0]         col_mask,
   input  logic [MAX_COLUMNS-1:0]         row_data,
   input  logic [lla_pkg::MASK_W-1:0]     birth_mask,
   input  logic [lla_pkg::MASK_W-1:0]     survive_mask,
   output logic [MAX_COLUMNS-1:0]         new_row,
   output logic [lla_pkg::COUNT_W-1:0]    births,
   output logic [lla_pkg::COUNT_W-1:0]    deaths
);

   import lla_pkg::*;

   logic [MAX_COLUMNS-1:0] above_ff, above_in;
   logic [MAX_COLUMNS-1:0] mid_ff, mid_in;
   logic [MAX_COLUMNS-1:0] below_ff, below_in;
   logic [MAX_COLUMNS-1:0] new_row_ff, new_row_in;
   logic [MAX_COLUMNS-1:0] load_row;
   logic [COUNT_W-1:0]     births_ff, births_in;
   logic [COUNT_W-1:0]     deaths_ff, deaths_in;
   logic [MASK_EXT_W-1:0]  birth_ext, survive_ext;
   logic [NBR_W-1:0]       nbr_count;
   logic                   left_ok, right_ok;
   logic                   alive, born, dies, next_alive;

   // window rotates right: bit 0 is the current column, bit 1 the next,
   // the top bit the previous one
   always_comb begin
      birth_ext   = MASK_EXT_W'(birth_mask);
      survive_ext = MASK_EXT_W'(survive_mask);
      load_row    = ctl.load_valid ? (row_data & col_mask) : '0;
      left_ok     = !ctl.first_col;
      right_ok    = !ctl.last_col;

      nbr_count = NBR_W'(above_ff[0]) + NBR_W'(below_ff[0])
                + NBR_W'(left_ok & above_ff[MAX_COLUMNS-1])
                + NBR_W'(left_ok & mid_ff[MAX_COLUMNS-1])
                + NBR_W'(left_ok & below_ff[MAX_COLUMNS-1])
                + NBR_W'(right_ok & above_ff[1])
                + NBR_W'(right_ok & mid_ff[1])
                + NBR_W'(right_ok & below_ff[1]);

      alive      = mid_ff[0];
      born       = ctl.in_region & !alive & birth_ext[nbr_count];
      dies       = ctl.in_region & alive & !survive_ext[nbr_count];
      next_alive = ctl.in_region & (born | (alive & !dies));
      new_row_in = {next_alive, new_row_ff[MAX_COLUMNS-1:1]};

      above_in  = above_ff;
      mid_in    = mid_ff;
      below_in  = below_ff;
      births_in = births_ff;
      deaths_in = deaths_ff;

      if (ctl.clear) begin
         above_in  = '0;
         mid_in    = '0;
         below_in  = '0;
         births_in = '0;
         deaths_in = '0;
      end else begin
         if (ctl.scan) begin
            above_in = {above_ff[0], above_ff[MAX_COLUMNS-1:1]};
            mid_in   = {mid_ff[0], mid_ff[MAX_COLUMNS-1:1]};
            below_in = {below_ff[0], below_ff[MAX_COLUMNS-1:1]};
            if (born && births_ff != COUNT_MAX) begin
               births_in = births_ff + 1'b1;
            end
            if (dies && deaths_ff != COUNT_MAX) begin
               deaths_in = deaths_ff + 1'b1;
            end
         end
         // after a full turn the rows are back in place, move down one row
         if (ctl.advance) begin
            above_in = mid_in;
            mid_in   = below_in;
            below_in = load_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      above_ff  <= above_in;
      mid_ff    <= mid_in;
      below_ff  <= below_in;
      births_ff <= births_in;
      deaths_ff <= deaths_in;
      if (ctl.scan) begin
         new_row_ff <= new_row_in;
      end
   end

   assign new_row = new_row_in;
   assign births  = births_ff;
   assign deaths  = deaths_ff;

endmodule

// ===== rtl/life_like_automaton_generation_core.sv =====
// Life-like automaton on a bounded, non-wrapping grid of up to MAX_ROWS x
// MAX_COLUMNS cells held as rows in two banks of one row memory. Every request
// transfer gives exactly one response transfer: for write and read of a cell
// the row is read at acceptance and the reply state then loads the response,
// with a read-modify-write for a cell write, once the output register is free.
// A generation step primes the window in states PRIME0 and PRIME1, then
// scans and replies: one neighbour-count unit processes one cell a cycle over
// every row and column of the full grid, fed by a three-row window that the
// single read port refills once per row; cells outside the region in use are
// stored as dead. Requests are not taken while an item is in progress, but a
// finished response may wait in the output register while the next request is
// accepted. After reset a clearing pass over every row zeroes the active bank;
// requests wait, register writes are taken at any time.
`timescale 1ns / 1ps

module life_like_automaton_generation_core #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lla_pkg::CMD_W-1:0]          req_cmd,
   input  logic [lla_pkg::COORD_W-1:0]        req_column,
   input  logic [lla_pkg::COORD_W-1:0]        req_row,
   input  logic                               req_alive_in,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_cell_value,
   output logic [lla_pkg::COUNT_W-1:0]        rsp_births,
   output logic [lla_pkg::COUNT_W-1:0]        rsp_deaths,
   output logic                               rsp_halted,
   // register writes
   input  logic                               csr_write_en,
   input  logic [lla_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lla_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   import lla_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int ADDR_W = ROW_W + 1;
   localparam int WU_W   = $clog2(MAX_COLUMNS + 1);
   localparam int HU_W   = $clog2(MAX_ROWS + 1);

   // control state
   lla_state_type         state_ff, state_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  bank_ff, bank_in;

   // registers
   logic [MASK_W-1:0]     birth_mask_ff, survive_mask_ff;
   logic [SIZE_W-1:0]     width_ff, height_ff;

   // latched request
   logic [CMD_W-1:0]      op_ff;
   logic                  inside_ff;
   logic [ROW_W-1:0]      cell_row_ff;
   logic [COL_W-1:0]      cell_col_ff;
   logic                  alive_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_cell_value_ff, rsp_cell_value_in;
   logic [COUNT_W-1:0]    rsp_births_ff, rsp_births_in;
   logic [COUNT_W-1:0]    rsp_deaths_ff, rsp_deaths_in;
   logic                  rsp_halted_ff, rsp_halted_in;
   logic                  rsp_load;
   logic                  out_free;

   logic                  req_accept;
   logic                  req_inside;
   logic                  scan_inside;
   logic                  col_last, row_last;
   logic [WU_W-1:0]       used_w;
   logic [HU_W-1:0]       used_h;
   logic [MAX_COLUMNS-1:0] col_mask;
   logic [MAX_COLUMNS-1:0] cell_row_mod;

   // row memory and cell unit
   logic                  mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]     mem_wr_addr, mem_rd_addr;
   logic [MAX_COLUMNS-1:0] mem_wr_data, mem_rd_data;
   lla_win_ctl_type       win_ctl;
   logic [MAX_COLUMNS-1:0] unit_new_row;
   logic [COUNT_W-1:0]    unit_births, unit_deaths;

   lla_row_mem #(
      .DATA_W (MAX_COLUMNS),
      .ADDR_W (ADDR_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lla_cell_unit #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_cell_unit (
      .clock        (clock),
      .ctl          (win_ctl),
      .col_mask     (col_mask),
      .row_data     (mem_rd_data),
      .birth_mask   (birth_mask_ff),
      .survive_mask (survive_mask_ff),
      .new_row      (unit_new_row),
      .births       (unit_births),
      .deaths       (unit_deaths)
   );

   // register writes, taken whenever they come
   always_ff @(posedge clock) begin
      if (reset) begin
         birth_mask_ff   <= BIRTH_RESET;
         survive_mask_ff <= SURVIVE_RESET;
         width_ff        <= SIZE_RESET;
         height_ff       <= SIZE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BIRTH_MASK:   birth_mask_ff   <= csr_write_data;
            CSR_SURVIVE_MASK: survive_mask_ff <= csr_write_data;
            CSR_WIDTH:        width_ff        <= csr_write_data[SIZE_W-1:0];
            CSR_HEIGHT:       height_ff       <= csr_write_data[SIZE_W-1:0];
         endcase
      end
   end

   // region in use, bounded to 1..MAX
   always_comb begin
      if (width_ff == '0) begin
         used_w = WU_W'(1);
      end else if (int'(width_ff) > MAX_COLUMNS) begin
         used_w = WU_W'(MAX_COLUMNS);
      end else begin
         used_w = WU_W'(width_ff);
      end
      if (height_ff == '0) begin
         used_h = HU_W'(1);
      end else if (int'(height_ff) > MAX_ROWS) begin
         used_h = HU_W'(MAX_ROWS);
      end else begin
         used_h = HU_W'(height_ff);
      end
      for (int i = 0; i < MAX_COLUMNS; i++) begin
         col_mask[i] = (i < int'(used_w));
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign req_inside  = (int'(req_column) < int'(used_w)) && (int'(req_row) < int'(used_h));
   assign scan_inside = (int'(col_ff) < int'(used_w)) && (int'(row_ff) < int'(used_h));
   assign col_last    = (col_ff == COL_W'(MAX_COLUMNS - 1));
   assign row_last    = (row_ff == ROW_W'(MAX_ROWS - 1));
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // single cell update of the fetched row
   always_comb begin
      cell_row_mod              = mem_rd_data;
      cell_row_mod[cell_col_ff] = alive_ff;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      bank_in     = bank_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = {bank_ff, row_ff};
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = {bank_ff, ROW_W'(req_row)};
      win_ctl     = '0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero the active bank, the other one is fully rewritten by a step
            mem_wr_en   = 1'b1;
            mem_wr_addr = {1'b0, row_ff};
            if (row_last) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_STEP) begin
                  mem_rd_en     = 1'b1;
                  mem_rd_addr   = {bank_ff, ROW_W'(0)};
                  win_ctl.clear = 1'b1;
                  row_in        = '0;
                  col_in        = '0;
                  state_in      = ST_PRIME0;
               end else begin
                  mem_rd_en = req_inside &&
                              (req_cmd == CMD_WRITE || req_cmd == CMD_READ);
                  state_in  = ST_REPLY;
               end
            end
         end
         ST_PRIME0: begin
            // row 0 arrives
            win_ctl.advance    = 1'b1;
            win_ctl.load_valid = 1'b1;
            mem_rd_en          = 1'b1;
            mem_rd_addr        = {bank_ff, ROW_W'(1)};
            state_in           = ST_PRIME1;
         end
         ST_PRIME1: begin
            // row 1 arrives, row 2 is fetched for the first row end
            win_ctl.advance    = 1'b1;
            win_ctl.load_valid = (int'(used_h) > 1);
            mem_rd_en          = 1'b1;
            mem_rd_addr        = {bank_ff, ROW_W'(2)};
            state_in           = ST_SCAN;
         end
         ST_SCAN: begin
            win_ctl.scan      = 1'b1;
            win_ctl.first_col = (col_ff == '0);
            win_ctl.last_col  = col_last;
            win_ctl.in_region = scan_inside;
            if (col_last) begin
               // row end: store the new row, slide the window, prefetch
               col_in             = '0;
               win_ctl.advance    = 1'b1;
               win_ctl.load_valid = (int'(row_ff) + 2 < int'(used_h));
               mem_wr_en          = 1'b1;
               mem_wr_addr        = {~bank_ff, row_ff};
               mem_wr_data        = unit_new_row;
               mem_rd_en          = 1'b1;
               mem_rd_addr        = {bank_ff, ROW_W'(int'(row_ff) + 3)};
               if (row_last) begin
                  state_in = ST_REPLY;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (op_ff == CMD_WRITE && inside_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = {bank_ff, cell_row_ff};
                  mem_wr_data = cell_row_mod;
               end
               if (op_ff == CMD_STEP) begin
                  bank_in = ~bank_ff;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         row_ff   <= '0;
         col_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         bank_ff  <= bank_in;
      end
   end

   // request fields kept for the reply
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff       <= req_cmd;
         inside_ff   <= req_inside;
         cell_row_ff <= ROW_W'(req_row);
         cell_col_ff <= COL_W'(req_column);
         alive_ff    <= req_alive_in;
      end
   end

   // response values, zero for anything but their own command
   always_comb begin
      rsp_cell_value_in = (op_ff == CMD_READ) && inside_ff && mem_rd_data[cell_col_ff];
      rsp_births_in     = (op_ff == CMD_STEP) ? unit_births : '0;
      rsp_deaths_in     = (op_ff == CMD_STEP) ? unit_deaths : '0;
      rsp_halted_in     = (op_ff == CMD_STEP) && (unit_births == '0);
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cell_value_ff <= rsp_cell_value_in;
         rsp_births_ff     <= rsp_births_in;
         rsp_deaths_ff     <= rsp_deaths_in;
         rsp_halted_ff     <= rsp_halted_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_value_ff;
   assign rsp_births     = rsp_births_ff;
   assign rsp_deaths     = rsp_deaths_ff;
   assign rsp_halted     = rsp_halted_ff;

   // a step reads the active bank and writes only the other one
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr[ADDR_W-1] != mem_rd_addr[ADDR_W-1]))
      else $error("row write and read hit the same bank");

   // every accepted request starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("request transfer left the sequencer idle");

   // a new response only comes out of the reply state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_REPLY))
      else $error("response raised outside the reply state");

   // the finished generation becomes the current grid
   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && op_ff == CMD_STEP && out_free)
      |=> (bank_ff != $past(bank_ff)))
      else $error("bank not swapped after a step");

endmodule

// ===== dv/life_like_automaton_generation_core_test.sv =====
`timescale 1ns / 1ps

module life_like_automaton_generation_core_test;
   import lla_pkg::*;

   localparam int GRID_COLS    = 64;
   localparam int GRID_ROWS    = 64;
   localparam int IDLE_PERCENT = 32;
   localparam int PHASE_ITEMS  = 20;
   localparam int HOLD_CYCLES  = 400;
   // a step scans the whole grid, so the limit allows every item to be a step
   // plus long stalls on both sides, several times over
   localparam int CYCLE_LIMIT  = 3_000_000;

   // the one code that the package enum leaves out
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               alive;
   } cell_request_type;

   typedef struct packed {
      logic               cell_value;
      logic [COUNT_W-1:0] births;
      logic [COUNT_W-1:0] deaths;
      logic               halted;
   } cell_result_type;

   // one line of the directed script: either a register write or a request,
   // the latter with or without a hand-written result
   typedef struct {
      bit                     is_register;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      cell_request_type       request;
      bit                     typed;
      cell_result_type        result;
   } script_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [CMD_W-1:0]       req_cmd;
   logic [COORD_W-1:0]     req_column;
   logic [COORD_W-1:0]     req_row;
   logic                   req_alive_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_cell_value;
   logic [COUNT_W-1:0]     rsp_births;
   logic [COUNT_W-1:0]     rsp_deaths;
   logic                   rsp_halted;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // predicted grid: two banks, the front one holds the current generation
   bit                     cells [2][GRID_ROWS][GRID_COLS];
   bit                     front_bank;
   logic [MASK_W-1:0]      birth_rule;
   logic [MASK_W-1:0]      survive_rule;
   logic [SIZE_W-1:0]      cols_in_use;
   logic [SIZE_W-1:0]      rows_in_use;

   cell_result_type        pending_results [$];
   script_row_type         script [$];
   int                     mismatches;
   int                     items_taken;

   // shared with the receiver, always changed just after a rising edge
   bit                     steady_flow;
   bit                     hold_asked;

   life_like_automaton_generation_core #(
      .MAX_COLUMNS(GRID_COLS),
      .MAX_ROWS   (GRID_ROWS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_alive_in  (req_alive_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_value(rsp_cell_value),
      .rsp_births    (rsp_births),
      .rsp_deaths    (rsp_deaths),
      .rsp_halted    (rsp_halted),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // region size as the block uses it: at least 1, at most the grid
   function automatic int clamp_size(input logic [SIZE_W-1:0] raw, input int limit);
      if (raw < 1) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   // behaviour of one request against the predicted grid and registers
   function automatic cell_result_type predict_response(input cell_request_type rq);
      cell_result_type res;
      int              w;
      int              h;
      int              n;
      int              rr;
      int              cc;
      int              born;
      int              died;
      bit              was;
      bit              back;
      res = '0;
      w = clamp_size(cols_in_use, GRID_COLS);
      h = clamp_size(rows_in_use, GRID_ROWS);
      case (rq.cmd)
         CMD_WRITE: begin
            // writes outside the region are dropped
            if (rq.column < w && rq.row < h) cells[front_bank][rq.row][rq.column] = rq.alive;
         end
         CMD_READ: begin
            if (rq.column < w && rq.row < h) res.cell_value = cells[front_bank][rq.row][rq.column];
         end
         CMD_STEP: begin
            back = ~front_bank;
            born = 0;
            died = 0;
            // whatever lies outside the region comes out dead
            for (int r = 0; r < GRID_ROWS; r++)
               for (int c = 0; c < GRID_COLS; c++)
                  cells[back][r][c] = 1'b0;
            for (int r = 0; r < h; r++) begin
               for (int c = 0; c < w; c++) begin
                  n = 0;
                  for (int dr = -1; dr <= 1; dr++) begin
                     for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
                           n += int'(cells[front_bank][rr][cc]);
                     end
                  end
                  was = cells[front_bank][r][c];
                  if (!was && birth_rule[n]) begin
                     cells[back][r][c] = 1'b1;
                     if (born < COUNT_MAX) born++;
                  end else if (was && !survive_rule[n]) begin
                     cells[back][r][c] = 1'b0;
                     if (died < COUNT_MAX) died++;
                  end else begin
                     cells[back][r][c] = was;
                  end
               end
            end
            front_bank = back;
            res.births = COUNT_W'(born);
            res.deaths = COUNT_W'(died);
            res.halted = (born == 0);
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic script_row_type known_row(input logic [CMD_W-1:0] cmd,
                                                input int col, row, alive, cell_bit,
                                                born, died, stop);
      script_row_type s;
      s.is_register = 1'b0;
      s.index       = '0;
      s.data        = '0;
      s.request     = '{cmd: cmd, column: COORD_W'(col), row: COORD_W'(row),
                        alive: alive[0]};
      s.typed       = 1'b1;
      s.result      = '{cell_value: cell_bit[0], births: COUNT_W'(born),
                        deaths: COUNT_W'(died), halted: stop[0]};
      return s;
   endfunction

   function automatic script_row_type item_row(input logic [CMD_W-1:0] cmd,
                                               input int col, row, alive);
      script_row_type s;
      s       = known_row(cmd, col, row, alive, 0, 0, 0, 0);
      s.typed = 1'b0;
      return s;
   endfunction

   function automatic script_row_type register_row(input logic [CSR_INDEX_W-1:0] index,
                                                   input int data);
      script_row_type s;
      s             = item_row(CMD_UNUSED, 0, 0, 0);
      s.is_register = 1'b1;
      s.index       = index;
      s.data        = CSR_DATA_W'(data);
      return s;
   endfunction

   function automatic void add_line(input script_row_type s);
      script = {script, s};
   endfunction

   // a cell address, mostly inside the region in use
   function automatic cell_request_type pick_cell(input logic [CMD_W-1:0] cmd);
      cell_request_type rq;
      int               w;
      int               h;
      w = clamp_size(cols_in_use, GRID_COLS);
      h = clamp_size(rows_in_use, GRID_ROWS);
      rq.cmd = cmd;
      if ($urandom_range(99) < 85) begin
         rq.column = COORD_W'($urandom_range(w - 1, 0));
         rq.row    = COORD_W'($urandom_range(h - 1, 0));
      end else begin
         rq.column = COORD_W'($urandom_range(63, 0));
         rq.row    = COORD_W'($urandom_range(63, 0));
      end
      rq.alive = ($urandom_range(99) < 75);
      return rq;
   endfunction

   // one request transfer; the expectation is queued once it is taken
   task automatic offer(input cell_request_type rq, input bit typed,
                        input cell_result_type typed_result);
      cell_result_type predicted;
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_cmd      <= rq.cmd;
      req_column   <= rq.column;
      req_row      <= rq.row;
      req_alive_in <= rq.alive;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_response(rq);
      pending_results = {pending_results, (typed ? typed_result : predicted)};
      items_taken++;
   endtask

   // stop offering and wait until every expected response has turned up
   task automatic wait_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic set_register(input logic [CSR_INDEX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      case (index)
         CSR_BIRTH_MASK:   birth_rule   = data;
         CSR_SURVIVE_MASK: survive_rule = data;
         CSR_WIDTH:        cols_in_use  = data[SIZE_W-1:0];
         CSR_HEIGHT:       rows_in_use  = data[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   // repeated rounds of seeding writes, one or two generations and some reads, with
   // a little noise (any command, any address) mixed into the seeding
   task automatic run_phase(input logic [MASK_W-1:0] birth, survive,
                            input logic [SIZE_W-1:0] cols, rows_n,
                            input bit steady, input bit squeeze);
      cell_request_type rq;
      int               first_item;
      wait_drained();
      steady_flow = steady;
      if (squeeze) hold_asked = 1'b1;
      set_register(CSR_BIRTH_MASK, birth);
      set_register(CSR_SURVIVE_MASK, survive);
      set_register(CSR_WIDTH, CSR_DATA_W'(cols));
      set_register(CSR_HEIGHT, CSR_DATA_W'(rows_n));
      first_item = items_taken;
      while (items_taken - first_item < PHASE_ITEMS) begin
         repeat ($urandom_range(8, 3)) begin
            if ($urandom_range(99) < 12) begin
               rq.cmd    = CMD_W'($urandom_range(3, 0));
               rq.column = COORD_W'($urandom_range(63, 0));
               rq.row    = COORD_W'($urandom_range(63, 0));
               rq.alive  = 1'($urandom_range(1, 0));
            end else begin
               rq = pick_cell(CMD_WRITE);
            end
            offer(rq, 1'b0, '0);
         end
         repeat ($urandom_range(2, 1)) offer(pick_cell(CMD_STEP), 1'b0, '0);
         repeat ($urandom_range(4, 1)) offer(pick_cell(CMD_READ), 1'b0, '0);
      end
   endtask

   // response side: random stalls, a quiet stretch, and one long hold-off
   // so that the block backs up into its request channel
   initial begin
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (steady_flow) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   function automatic void check_field(input string label, input logic [COUNT_W-1:0] want,
                                       input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endfunction

   // every response transfer against the oldest expectation
   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response transfer with nothing expected", $time);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("cell_value", COUNT_W'(want.cell_value), COUNT_W'(rsp_cell_value));
            check_field("births", want.births, rsp_births);
            check_field("deaths", want.deaths, rsp_deaths);
            check_field("halted", COUNT_W'(want.halted), COUNT_W'(rsp_halted));
         end
      end
   end

   // watchdog
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("life_like_automaton_generation_core_test: done, errors");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = '0;
      req_column     = '0;
      req_row        = '0;
      req_alive_in   = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_write_data = '0;
      steady_flow    = 1'b0;
      hold_asked     = 1'b0;
      mismatches     = 0;
      items_taken    = 0;
      front_bank     = 1'b0;
      birth_rule     = BIRTH_RESET;
      survive_rule   = SURVIVE_RESET;
      cols_in_use    = SIZE_RESET;
      rows_in_use    = SIZE_RESET;

      // empty grid after reset, corner cells, unused command
      add_line(known_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
      add_line(known_row(CMD_READ, 63, 63, 1, 0, 0, 0, 0));
      add_line(known_row(CMD_WRITE, 0, 0, 1, 0, 0, 0, 0));
      add_line(known_row(CMD_WRITE, 63, 63, 1, 0, 0, 0, 0));
      add_line(known_row(CMD_READ, 0, 0, 0, 1, 0, 0, 0));
      add_line(known_row(CMD_READ, 63, 63, 0, 1, 0, 0, 0));
      add_line(known_row(CMD_UNUSED, 63, 63, 1, 0, 0, 0, 0));
      // vertical blinker, lonely corners die on the first generation
      add_line(known_row(CMD_WRITE, 20, 10, 1, 0, 0, 0, 0));
      add_line(known_row(CMD_WRITE, 20, 11, 1, 0, 0, 0, 0));
      add_line(known_row(CMD_WRITE, 20, 12, 1, 0, 0, 0, 0));
      add_line(item_row(CMD_STEP, 0, 0, 0));
      add_line(item_row(CMD_READ, 19, 11, 0));
      add_line(known_row(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0));
      add_line(item_row(CMD_STEP, 63, 63, 1));
      // shrunken region: live cells outside read as dead, writes there dropped
      add_line(register_row(CSR_WIDTH, 8));
      add_line(register_row(CSR_HEIGHT, 8));
      add_line(known_row(CMD_READ, 20, 11, 0, 0, 0, 0, 0));
      add_line(known_row(CMD_WRITE, 40, 40, 1, 0, 0, 0, 0));
      // sizes past both ends clamp, to a single column and to the full height; the step drops the rest
      add_line(register_row(CSR_WIDTH, 0));
      add_line(register_row(CSR_HEIGHT, 127));
      add_line(item_row(CMD_STEP, 0, 0, 0));
      add_line(register_row(CSR_WIDTH, 64));
      add_line(register_row(CSR_HEIGHT, 64));
      add_line(item_row(CMD_READ, 20, 11, 0));
      add_line(item_row(CMD_READ, 40, 40, 0));
      // full masks fill the grid, empty masks then kill every cell
      add_line(register_row(CSR_BIRTH_MASK, 'h1FF));
      add_line(register_row(CSR_SURVIVE_MASK, 'h1FF));
      add_line(item_row(CMD_STEP, 0, 0, 0));
      add_line(register_row(CSR_BIRTH_MASK, 0));
      add_line(register_row(CSR_SURVIVE_MASK, 0));
      add_line(known_row(CMD_STEP, 0, 0, 0, 0, 0, 4096, 1));
      add_line(known_row(CMD_STEP, 5, 5, 1, 0, 0, 0, 1));
      add_line(known_row(CMD_READ, 32, 32, 0, 0, 0, 0, 0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_register) begin
            wait_drained();
            set_register(script[i].index, script[i].data);
         end else begin
            offer(script[i].request, script[i].typed, script[i].result);
         end
      end

      // classic rule on a small board, with the long receiver hold-off
      run_phase(9'd8, 9'd12, 7'd8, 7'd8, 1'b0, 1'b1);
      // random rule on a small board, no idling on either side
      run_phase(MASK_W'($urandom_range(511, 0)), MASK_W'($urandom_range(511, 0)),
                SIZE_W'($urandom_range(16, 1)), SIZE_W'($urandom_range(16, 1)),
                1'b1, 1'b0);
      // everything born, nothing survives, on a single clamped row
      run_phase(9'h1FF, 9'h000, 7'd127, 7'd0, 1'b0, 1'b0);
      // nothing born, everything survives, full grid
      run_phase(9'h000, 9'h1FF, 7'd64, 7'd64, 1'b0, 1'b0);
      // random rule, any size the register holds
      run_phase(MASK_W'($urandom_range(511, 0)), MASK_W'($urandom_range(511, 0)),
                SIZE_W'($urandom_range(127, 0)), SIZE_W'($urandom_range(127, 0)),
                1'b0, 1'b0);

      wait_drained();
      // a short settle to catch stray response transfers
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("life_like_automaton_generation_core_test: done, clean");
      else
         $display("life_like_automaton_generation_core_test: done, errors");
      $finish;
   end

endmodule
